>>> rtl/pss_pkg.sv
// ============================================================================
// pss_pkg: shared types and constants for the polynomial secret share block
// Field widths, command codes and the evaluation point offset.
// ============================================================================
package pss_pkg;

    localparam int VALUE_W = 64;
    localparam int PARTY_W = 2;
    localparam int INDEX_W = 2;
    localparam int X_OFFSET = 2;

    typedef logic [VALUE_W-1:0] word_t;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHARE = 1'b1;

endpackage

>>> rtl/pss_mac.sv
// ============================================================================
// pss_mac: shared multiply-add unit for one Horner step
// Forms acc * x + addend, wrapped to the word width.
// ============================================================================
module pss_mac
    import pss_pkg::*;
#(
    parameter int X_W = 3
)
(
    input  word_t          acc,
    input  logic [X_W-1:0] x,
    input  word_t          addend,
    output word_t          result
);

    logic [VALUE_W+X_W-1:0] product;

    // The evaluation point is narrow, so this is a 64 by X_W multiplier.
    assign product = acc * x;
    assign result  = product[VALUE_W-1:0] + addend;

endmodule

>>> rtl/polynomial_secret_share.sv
// ============================================================================
// polynomial_secret_share: Shamir-style splitting of 64-bit secrets
// Loads higher-order coefficients and emits one share per party.
// ============================================================================
// A load transaction (command 0) writes value into the coefficient of power
// coef_index; indexes of zero or of NUM_COEFFS and above are ignored. A load
// yields no result. A share transaction (command 1) uses value as
// the constant term and evaluates the polynomial by Horner's rule at
// x = party + 2 for each party in turn, producing one result transaction per
// party with last set on the final one. All arithmetic wraps modulo 2^64.
// Every coefficient that a share reads must have been loaded beforehand; the
// store has no reset value. One shared 64 by X_W-bit multiply-add unit
// (3-bit at the default sizes) performs every Horner step, so the parties
// are evaluated one after another and the block takes no new transaction
// until the final share has been formed. The unit pauses while a finished
// share waits in the output register and the next one is ready, so a
// stalled output lengthens the item. The last share may still wait to be
// taken while the next transaction is accepted.
// ============================================================================
module polynomial_secret_share
    import pss_pkg::*;
#(
    parameter int NUM_COEFFS  = 4,
    parameter int NUM_PARTIES = 3
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  logic [INDEX_W-1:0]         coef_index,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [PARTY_W-1:0]         party,
    output logic signed [VALUE_W-1:0]  share,
    output logic                       last
);

    // Width of the coefficient store index (power minus one).
    localparam int IDX_W = (NUM_COEFFS > 2) ? $clog2(NUM_COEFFS - 1) : 1;
    // Width of the Horner power counter, which runs from NUM_COEFFS-2 to 0.
    localparam int PW_W  = $clog2(NUM_COEFFS);
    // Width of the party counter.
    localparam int P_W   = $clog2(NUM_PARTIES);
    // Width of the evaluation point, whose largest value is NUM_PARTIES + 1.
    localparam int X_W   = $clog2(NUM_PARTIES + X_OFFSET);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    // Coefficients of powers 1 to NUM_COEFFS-1, held at index power - 1.
    word_t coef_mem [NUM_COEFFS-1];

    logic              state_reg,     state_next;
    logic [PW_W-1:0]   pw_reg,        pw_next;
    logic [P_W-1:0]    party_cnt_reg, party_cnt_next;
    word_t             acc_reg,       acc_next;
    word_t             secret_reg,    secret_next;
    logic              out_valid_reg, out_valid_next;
    logic [PARTY_W-1:0] party_reg,    party_next;
    word_t             share_reg,     share_next;
    logic              last_reg,      last_next;

    logic              in_accept;
    logic              load_write;
    logic [31:0]       write_power;
    logic [IDX_W-1:0]  write_idx;
    logic [IDX_W-1:0]  read_idx;
    logic [IDX_W-1:0]  top_idx;
    logic [X_W-1:0]    x_point;
    word_t             addend;
    word_t             mac_result;
    logic              final_step;
    logic              final_party;
    logic              out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // A load is only stored for powers 1 to NUM_COEFFS-1.
    assign write_power = 32'(coef_index);
    assign load_write  = in_accept && (command == CMD_LOAD)
                         && (write_power >= 32'd1)
                         && (write_power < 32'(NUM_COEFFS));
    assign write_idx   = IDX_W'(write_power - 32'd1);

    always_ff @(posedge clk)
    begin
        if (load_write)
        begin
            coef_mem[write_idx] <= value;
        end
    end

    // Horner addend: a stored coefficient, or the secret on the final step.
    assign final_step  = (pw_reg == '0);
    assign read_idx    = IDX_W'(pw_reg - PW_W'(1));
    assign top_idx     = IDX_W'(NUM_COEFFS - 2);
    assign addend      = final_step ? secret_reg : coef_mem[read_idx];
    assign x_point     = X_W'(party_cnt_reg) + X_W'(X_OFFSET);
    assign final_party = (party_cnt_reg == P_W'(NUM_PARTIES - 1));
    assign out_free    = !out_valid_reg || !out_stall;

    pss_mac #(
        .X_W (X_W)
    ) u_mac (
        .acc    (acc_reg),
        .x      (x_point),
        .addend (addend),
        .result (mac_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        pw_next        = pw_reg;
        party_cnt_next = party_cnt_reg;
        acc_next       = acc_reg;
        secret_next    = secret_reg;
        out_valid_next = out_valid_reg;
        party_next     = party_reg;
        share_next     = share_reg;
        last_next      = last_reg;

        // The consumer has taken the pending share.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (command == CMD_SHARE))
                begin
                    secret_next    = value;
                    acc_next       = coef_mem[top_idx];
                    pw_next        = PW_W'(NUM_COEFFS - 2);
                    party_cnt_next = '0;
                    state_next     = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!final_step)
                begin
                    acc_next = mac_result;
                    pw_next  = pw_reg - PW_W'(1);
                end
                else if (out_free)
                begin
                    // Share complete: hand it over and start the next party.
                    out_valid_next = 1'b1;
                    share_next     = mac_result;
                    party_next     = PARTY_W'(party_cnt_reg);
                    last_next      = final_party;
                    acc_next       = coef_mem[top_idx];
                    pw_next        = PW_W'(NUM_COEFFS - 2);
                    party_cnt_next = party_cnt_reg + P_W'(1);
                    if (final_party)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pw_reg        <= pw_next;
        party_cnt_reg <= party_cnt_next;
        acc_reg       <= acc_next;
        secret_reg    <= secret_next;
        party_reg     <= party_next;
        share_reg     <= share_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign party     = party_reg;
    assign share     = share_reg;
    assign last      = last_reg;

endmodule

>>> rtl/pss_checker.sv
// ============================================================================
// pss_port_checker: port-level checks for the polynomial secret share block
// Watches the handshakes over time and is bound to the top level.
// ============================================================================
module pss_port_checker
    import pss_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      command,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [PARTY_W-1:0]        party,
    input logic signed [VALUE_W-1:0] share,
    input logic                      last
);

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(share) && $stable(party)
                                   && $stable(last))
    else $error("stalled result changed");

    // A load leaves the block ready for another transaction in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == CMD_LOAD) |=> !in_stall)
    else $error("block busy after a load");

    // A share keeps the block busy while it is evaluated.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == CMD_SHARE) |=> in_stall)
    else $error("block free straight after a share");

    // Once the final share of a secret is taken, any result that follows at
    // once belongs to the next secret and so starts again at party zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last |=> !out_valid || (party == '0))
    else $error("result after the final share does not start at party zero");

endmodule

bind polynomial_secret_share pss_port_checker u_pss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .party     (party),
    .share     (share),
    .last      (last)
);

>>> tb/pss_checker.sv
// ============================================================================
// pss_checker: prediction and comparison for polynomial_secret_share
// Predicts every share from the accepted transactions and compares each
// result, field by field, in order.
// ============================================================================
module pss_checker
    import pss_pkg::*;
#(
    parameter int NUM_COEFFS  = 4,
    parameter int NUM_PARTIES = 3
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                command,
    input  logic [INDEX_W-1:0]  coef_index,
    input  logic [VALUE_W-1:0]  value,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [PARTY_W-1:0]  party,
    input  logic [VALUE_W-1:0]  share,
    input  logic                last,
    output int unsigned         fail_count,
    output int unsigned         shares_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PRINT_LIMIT = 100;

    typedef struct packed {
        logic [PARTY_W-1:0] party;
        word_t              share;
        logic               last;
    } share_t;

    share_t share_q[$];
    share_t oldest;
    share_t next_share;
    word_t  coef_mem [1:NUM_COEFFS-1];

    // Horner evaluation of the stored polynomial at x, with the secret as
    // the constant term; 64-bit products wrap just as the hardware does.
    function automatic word_t horner_eval(input word_t secret, input word_t x);
        word_t acc;
        acc = coef_mem[NUM_COEFFS-1];
        for (int pw = NUM_COEFFS - 2; pw >= 1; pw--)
            acc = acc * x + coef_mem[pw];
        return acc * x + secret;
    endfunction

    task automatic report_fault(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            share_q.delete();
            fail_count     = 0;
            shares_pending = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (command == CMD_LOAD)
                begin
                    if (coef_index >= 1 && coef_index < NUM_COEFFS)
                        coef_mem[coef_index] = value;
                end
                else
                begin
                    for (int p = 0; p < NUM_PARTIES; p++)
                    begin
                        next_share.party = PARTY_W'(p);
                        next_share.share = horner_eval(value, word_t'(p + X_OFFSET));
                        next_share.last  = (p == NUM_PARTIES - 1);
                        share_q = {share_q, next_share};
                    end
                end
            end

            if (out_valid && !out_stall)
            begin
                if (share_q.size() == 0)
                    report_fault($sformatf("unexpected share party=%0d share=%h",
                                           party, share));
                else
                begin
                    oldest = share_q.pop_front();
                    if (party !== oldest.party)
                        report_fault($sformatf("party got %0d want %0d",
                                               party, oldest.party));
                    if (share !== oldest.share)
                        report_fault($sformatf("share (party %0d) got %h want %h",
                                               oldest.party, share, oldest.share));
                    if (last !== oldest.last)
                        report_fault($sformatf("last (party %0d) got %b want %b",
                                               oldest.party, last, oldest.last));
                end
            end

            shares_pending = share_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// ============================================================================
// tb_top: testbench for polynomial_secret_share
// Drives load and share transactions with random gaps and output stalls,
// and takes the verdict from the checker's failure count.
// ============================================================================
module tb_top
    import pss_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_COEFFS  = 4;
    localparam int NUM_PARTIES = 3;

    // Number of counted random transactions; loads to the constant term are
    // ignored by the block and so do not count.
    localparam int unsigned RANDOM_ITEMS = 90;
    // Cycles allowed after the last expected share for any stray output.
    localparam int unsigned DRAIN_CYCLES = 24;
    // Far beyond the slowest legal run.
    localparam int unsigned CYCLE_LIMIT  = 200000;

    localparam word_t ALL_ZERO = '0;
    localparam word_t ALL_ONES = '1;
    localparam word_t MAX_POS  = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam word_t MIN_NEG  = {1'b1, {(VALUE_W-1){1'b0}}};

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic               command    = CMD_LOAD;
    logic [INDEX_W-1:0] coef_index = '0;
    word_t              value      = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [PARTY_W-1:0] party;
    word_t              share;
    logic               last;

    int unsigned fail_count;
    int unsigned shares_pending;
    int unsigned cycle_count    = 0;
    // Idle and stall rates in percent, changed between phases of the run.
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    // Free-running clock, 8 ns period.
    initial
    begin
        forever #4 clk = ~clk;
    end

    polynomial_secret_share #(
        .NUM_COEFFS  (NUM_COEFFS),
        .NUM_PARTIES (NUM_PARTIES)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .coef_index (coef_index),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .party      (party),
        .share      (share),
        .last       (last)
    );

    pss_checker #(
        .NUM_COEFFS  (NUM_COEFFS),
        .NUM_PARTIES (NUM_PARTIES)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .coef_index     (coef_index),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .party          (party),
        .share          (share),
        .last           (last),
        .fail_count     (fail_count),
        .shares_pending (shares_pending)
    );

    // The receiving side stalls at random, at the rate of the current phase.
    // A fresh decision is made every cycle, so stalls land on every step of
    // the block's multiply-add sequence.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Presents one transaction, after a random number of idle cycles, and
    // returns at the rising edge at which the block takes it. The stall is
    // looked at on the falling edge, when every signal has settled, so the
    // decision never depends on the order of events at the rising edge.
    task automatic send_txn(input logic cmd, input logic [INDEX_W-1:0] idx,
                            input word_t val);
        logic accepted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        coef_index <= idx;
        value      <= val;
        do
        begin
            @(negedge clk);
            accepted = !in_stall;
            @(posedge clk);
        end
        while (!accepted);
    endtask

    initial
    begin
        int unsigned   n_counted;
        logic          cmd;
        logic [INDEX_W-1:0] idx;
        word_t         val;

        n_counted = 0;

        // Reset is held at the start and released on a rising edge.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First phase: the sender idles a quarter of the time and the
        // receiver stalls more often than not.
        src_idle_pct   = 25;
        sink_stall_pct = 60;

        // Directed part. Every coefficient is loaded before the first share,
        // since the store holds nothing defined until it is written.
        send_txn(CMD_LOAD,  2'd1, ALL_ZERO);
        send_txn(CMD_LOAD,  2'd2, ALL_ZERO);
        send_txn(CMD_LOAD,  2'd3, ALL_ZERO);
        // With a zero polynomial every share equals the secret.
        send_txn(CMD_SHARE, 2'd0, ALL_ZERO);
        send_txn(CMD_SHARE, 2'd3, MAX_POS);
        send_txn(CMD_SHARE, 2'd0, MIN_NEG);
        // Extreme coefficients, so that every Horner step wraps.
        send_txn(CMD_LOAD,  2'd3, ALL_ONES);
        send_txn(CMD_LOAD,  2'd2, MIN_NEG);
        send_txn(CMD_LOAD,  2'd1, MAX_POS);
        send_txn(CMD_SHARE, 2'd1, ALL_ONES);
        // A load to the constant term must leave the store untouched.
        send_txn(CMD_LOAD,  2'd0, 64'h0123_4567_89ab_cdef);
        send_txn(CMD_SHARE, 2'd2, 64'd1);
        send_txn(CMD_LOAD,  2'd1, ALL_ONES);
        send_txn(CMD_LOAD,  2'd2, ALL_ONES);
        send_txn(CMD_SHARE, 2'd0, MIN_NEG);
        // Back-to-back shares reuse the same coefficients.
        send_txn(CMD_SHARE, 2'd3, {$urandom(), $urandom()});
        send_txn(CMD_SHARE, 2'd1, {$urandom(), $urandom()});
        send_txn(CMD_LOAD,  2'd3, MAX_POS);
        send_txn(CMD_LOAD,  2'd0, ALL_ONES);
        send_txn(CMD_SHARE, 2'd0, ALL_ZERO);

        // Random part: a mix of loads and shares with random content, split
        // into three phases of idling behaviour.
        while (n_counted < RANDOM_ITEMS)
        begin
            if (n_counted < RANDOM_ITEMS / 3)
            begin
                src_idle_pct   = 25;
                sink_stall_pct = 60;
            end
            else if (n_counted < 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct   = 60;
                sink_stall_pct = 25;
            end
            else
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end

            cmd = ($urandom_range(0, 99) < 55) ? CMD_SHARE : CMD_LOAD;
            idx = INDEX_W'($urandom_range(0, 3));
            case ($urandom_range(0, 15))
                0:       val = ALL_ZERO;
                1:       val = ALL_ONES;
                2:       val = MAX_POS;
                3:       val = MIN_NEG;
                default: val = {$urandom(), $urandom()};
            endcase

            send_txn(cmd, idx, val);
            if (!(cmd == CMD_LOAD && idx == 0))
                n_counted++;
        end
        in_valid <= 1'b0;

        // Wait for every predicted share to come out, then give any stray
        // result a chance to show itself before the verdict.
        do
            @(negedge clk);
        while (shares_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
